/* src/afl_pkg.sv */
// afl_pkg: shared types, constants and command codes of the lockout controller
// no dependencies; imported by the register file, the channel interfaces and the top level
package afl_pkg;

    // fixed design constants
    localparam int unsigned BASE_LOCKOUT_SECONDS = 1;
    localparam int unsigned ACTIVE_SHIFT_LIMIT   = 16;
    localparam logic [31:0] CENTURY_SECONDS      = 32'd3155760000;
    localparam logic [7:0]  PARK_COUNT           = 8'd254;

    // widths of the lockout delay arithmetic
    localparam int unsigned BASE_W  = $clog2(BASE_LOCKOUT_SECONDS + 1);
    localparam int unsigned PROD_W  = 8 + BASE_W;
    localparam int unsigned SHIFT_W = $clog2(ACTIVE_SHIFT_LIMIT + 1);
    localparam int unsigned DELAY_W = PROD_W + ACTIVE_SHIFT_LIMIT;
    localparam int unsigned SUM_W   = ((DELAY_W > 32) ? DELAY_W : 32) + 1;

    // command codes
    localparam logic [2:0] CMD_QUERY    = 3'd0;
    localparam logic [2:0] CMD_FAIL     = 3'd1;
    localparam logic [2:0] CMD_SUCCESS  = 3'd2;
    localparam logic [2:0] CMD_TICK     = 3'd3;
    localparam logic [2:0] CMD_ACTIVITY = 3'd4;

    // register map
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned IDX_W  = 3;
    localparam logic [IDX_W-1:0] REG_START_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_FAIL_COUNT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_ERASE_FAIL      = 3'd2;
    localparam logic [IDX_W-1:0] REG_AGGRESSIVENESS  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RELOCK_SECONDS  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RELOCK_ANY_AUTH = 3'd5;

    typedef struct packed {
        logic [7:0]  start_threshold;
        logic [7:0]  max_fail_count;
        logic [7:0]  erase_fail_count;
        logic [7:0]  aggressiveness;
        logic [15:0] relock_seconds;
        logic        relock_on_any_auth;
    } afl_cfg_t;

    localparam afl_cfg_t CFG_RESET = '{
        start_threshold:    8'd0,
        max_fail_count:     8'd0,
        erase_fail_count:   8'd0,
        aggressiveness:     8'd1,
        relock_seconds:     16'd300,
        relock_on_any_auth: 1'b1
    };

endpackage

/* src/afl_evt_if.sv */
// afl_evt_if: event channel (command and current time) with valid/ready
// depends on afl_pkg
interface afl_evt_if
    import afl_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] now_seconds;

    modport source (output valid, cmd, now_seconds, input ready);
    modport sink   (input valid, cmd, now_seconds, output ready);
endinterface

/* src/afl_res_if.sv */
// afl_res_if: result channel (access status and counters) with valid/ready
// depends on afl_pkg
interface afl_res_if
    import afl_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        access_allowed;
    logic        erase_request;
    logic        relock_expired;
    logic [31:0] locked_until;
    logic [7:0]  fail_total;

    modport source (output valid, access_allowed, erase_request, relock_expired,
                    locked_until, fail_total, input ready);
    modport sink   (input valid, access_allowed, erase_request, relock_expired,
                    locked_until, fail_total, output ready);
endinterface

/* src/afl_regs.sv */
// afl_regs: apb configuration register file of the lockout controller
// depends on afl_pkg for the register map, the config struct and reset values
module afl_regs
    import afl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output afl_cfg_t          cfg
);

    afl_cfg_t         cfg_reg;
    afl_cfg_t         cfg_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_START_THRESHOLD: cfg_next.start_threshold    = pwdata[7:0];
                REG_MAX_FAIL_COUNT:  cfg_next.max_fail_count     = pwdata[7:0];
                REG_ERASE_FAIL:      cfg_next.erase_fail_count   = pwdata[7:0];
                REG_AGGRESSIVENESS:  cfg_next.aggressiveness     = pwdata[7:0];
                REG_RELOCK_SECONDS:  cfg_next.relock_seconds     = pwdata[15:0];
                REG_RELOCK_ANY_AUTH: cfg_next.relock_on_any_auth = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    always_comb
    begin
        case (idx)
            REG_START_THRESHOLD: prdata = {24'd0, cfg_reg.start_threshold};
            REG_MAX_FAIL_COUNT:  prdata = {24'd0, cfg_reg.max_fail_count};
            REG_ERASE_FAIL:      prdata = {24'd0, cfg_reg.erase_fail_count};
            REG_AGGRESSIVENESS:  prdata = {24'd0, cfg_reg.aggressiveness};
            REG_RELOCK_SECONDS:  prdata = {16'd0, cfg_reg.relock_seconds};
            REG_RELOCK_ANY_AUTH: prdata = {31'd0, cfg_reg.relock_on_any_auth};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

/* src/auth_failure_lockout_backoff.sv */
// auth_failure_lockout_backoff: top level of the failed-authentication lockout controller
// depends on afl_pkg, afl_evt_if, afl_res_if and afl_regs
//
// usage:
//   evt  - event channel (valid/ready): cmd and now_seconds. one transaction per event;
//          cmd 0 query, 1 auth failure, 2 auth success, 3 one-second tick,
//          4 authorized activity; codes 5 to 7 behave as a query
//   res  - result channel (valid/ready): exactly one transaction per event, in order,
//          carrying access_allowed, erase_request, relock_expired, locked_until and
//          fail_total as they stand after that event
//   apb  - configuration registers at byte addresses 0,4,..,20; write only while idle
// latency: an event accepted at edge n is registered, processed and presented on res
//   at edge n+1, so the result can be taken at edge n+2 at the earliest
// throughput: one event per cycle; failure count, lockout end and idle ticks update
//   in the same cycle the event leaves the input register, so the next event sees them
// stall: while res is held, one more event waits in the input register; evt.ready
//   drops only when both the input and the result register are full
// reset: counters and lockout cleared, registers at their reset values, both
//   registers empty
module auth_failure_lockout_backoff
    import afl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    afl_evt_if.sink           evt,
    afl_res_if.source         res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    afl_cfg_t cfg;

    afl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic        s1_valid_reg;
    logic [2:0]  s1_cmd_reg;
    logic [31:0] s1_now_reg;
    logic        s1_fire;
    logic        evt_fire;

    // state
    logic [7:0]  fail_cnt_reg;
    logic [7:0]  fail_cnt_next;
    logic [31:0] lockout_end_reg;
    logic [31:0] lockout_end_next;
    logic [31:0] idle_ticks_reg;
    logic [31:0] idle_ticks_next;

    // result register
    logic        out_valid_reg;
    logic        allowed_reg;
    logic        erase_reg;
    logic        relock_reg;
    logic [31:0] locked_reg;
    logic [7:0]  total_reg;

    // step logic
    logic [7:0]         count;
    logic [7:0]         act_raw;
    logic [SHIFT_W-1:0] active;
    logic [PROD_W-1:0]  delay_base;
    logic [DELAY_W-1:0] delay;
    logic [SUM_W-1:0]   end_sum;
    logic [31:0]        end_sat;
    logic               step_erase;
    logic [32:0]        cur_time;
    logic               step_allowed;
    logic               step_relock;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready = !s1_valid_reg || s1_fire;
    assign evt_fire = evt.valid && evt.ready;

    always_comb
    begin
        count = (fail_cnt_reg == 8'hFF) ? 8'hFF : fail_cnt_reg + 8'd1;

        if (count > cfg.max_fail_count)
            act_raw = (cfg.max_fail_count >= cfg.start_threshold)
                      ? cfg.max_fail_count - cfg.start_threshold
                      : 8'(ACTIVE_SHIFT_LIMIT);
        else
            act_raw = count - cfg.start_threshold;
        active = (act_raw > 8'(ACTIVE_SHIFT_LIMIT)) ? SHIFT_W'(ACTIVE_SHIFT_LIMIT)
                                                    : SHIFT_W'(act_raw);

        delay_base = PROD_W'(cfg.aggressiveness) * PROD_W'(BASE_LOCKOUT_SECONDS);
        delay      = DELAY_W'(delay_base) << active;
        end_sum    = SUM_W'(s1_now_reg) + SUM_W'(delay);
        end_sat    = (end_sum[SUM_W-1:32] != '0) ? 32'hFFFF_FFFF : end_sum[31:0];

        fail_cnt_next    = fail_cnt_reg;
        lockout_end_next = lockout_end_reg;
        idle_ticks_next  = idle_ticks_reg;
        step_erase       = 1'b0;

        case (s1_cmd_reg)
            CMD_FAIL:
            begin
                fail_cnt_next = count;
                if (count >= cfg.start_threshold)
                begin
                    if (cfg.erase_fail_count != 8'd0 && count >= cfg.erase_fail_count)
                        step_erase = 1'b1;
                    else
                    begin
                        if (count > cfg.max_fail_count)
                            fail_cnt_next = PARK_COUNT;
                        lockout_end_next = end_sat;
                    end
                end
            end
            CMD_SUCCESS:
            begin
                fail_cnt_next    = 8'd0;
                lockout_end_next = 32'd0;
                idle_ticks_next  = 32'd0;
            end
            CMD_TICK:
            begin
                if (idle_ticks_reg != 32'hFFFF_FFFF)
                    idle_ticks_next = idle_ticks_reg + 32'd1;
            end
            CMD_ACTIVITY:
            begin
                if (cfg.relock_on_any_auth)
                    idle_ticks_next = 32'd0;
            end
            default: ;
        endcase

        // century wrap: compare against now shifted up one century
        if (lockout_end_next >= CENTURY_SECONDS && s1_now_reg < CENTURY_SECONDS)
            cur_time = 33'(s1_now_reg) + 33'(CENTURY_SECONDS);
        else
            cur_time = 33'(s1_now_reg);
        step_allowed = cur_time >= 33'(lockout_end_next);
        step_relock  = idle_ticks_next > 32'(cfg.relock_seconds);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            fail_cnt_reg    <= 8'd0;
            lockout_end_reg <= 32'd0;
            idle_ticks_reg  <= 32'd0;
        end
        else
        begin
            if (evt.ready)
                s1_valid_reg <= evt.valid;
            if (s1_fire)
            begin
                out_valid_reg   <= 1'b1;
                fail_cnt_reg    <= fail_cnt_next;
                lockout_end_reg <= lockout_end_next;
                idle_ticks_reg  <= idle_ticks_next;
            end
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            s1_cmd_reg <= evt.cmd;
            s1_now_reg <= evt.now_seconds;
        end
        if (s1_fire)
        begin
            allowed_reg <= step_allowed;
            erase_reg   <= step_erase;
            relock_reg  <= step_relock;
            locked_reg  <= lockout_end_next;
            total_reg   <= fail_cnt_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.access_allowed = allowed_reg;
    assign res.erase_request  = erase_reg;
    assign res.relock_expired = relock_reg;
    assign res.locked_until   = locked_reg;
    assign res.fail_total     = total_reg;

    // a success leaves count and lockout cleared
    a_success_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_cmd_reg == CMD_SUCCESS |=> fail_cnt_reg == 8'd0
                                                && lockout_end_reg == 32'd0)
        else $error("success did not clear failure state");

    // an erase request only comes from a failure
    a_erase_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && step_erase |-> s1_cmd_reg == CMD_FAIL)
        else $error("erase request on a non-failure event");

    // every processed event produces a result
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("processed event lost its result");

    // the event channel only stalls with the input register full
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !evt.ready |-> s1_valid_reg && out_valid_reg)
        else $error("event channel stalled with room available");

    // the lockout end never moves on a tick or activity event
    a_lockout_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_cmd_reg == CMD_TICK || s1_cmd_reg == CMD_ACTIVITY)
        |=> $stable(lockout_end_reg))
        else $error("lockout end changed on a tick or activity event");

endmodule
